FILE: rtl/core/spo2r_pkg.sv
// Shared types and constants for the SpO2 ratio-of-ratios estimator.
`timescale 1ns / 1ps
`default_nettype none
package spo2r_pkg;

  // Window storage
  localparam int MAX_WINDOW = 128;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);

  // Field widths
  localparam int SAMPLE_W = 18;
  localparam int SPO2_W   = 15;
  localparam int MEAN_W   = 34;
  localparam int RES_W    = 27;
  localparam int RMS_W    = 27;
  localparam int SUM_W    = 54 + SLOT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FINGER_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AC_RMS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPO2_FLOOR       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPO2_CEILING     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 3'd6;

  // Curve coefficients (Q.16) and ratio limits (Q1.16)
  localparam logic [21:0] COEF_A   = 22'd2953052;
  localparam logic [20:0] COEF_B   = 21'd1989280;
  localparam logic [22:0] COEF_C   = 23'd6412370;
  localparam logic [16:0] R_LOW    = 17'd26214;
  localparam logic [16:0] R_ONE    = 17'd65536;
  localparam logic [MEAN_W-1:0] MEAN_ONE = 34'd65536;

  // Divide / square-root unit
  localparam int DSQ_W      = 64;
  localparam int DSQ_DIV_W  = 48;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int DSQ_CNT_W  = 7;

  typedef enum logic [0:0] {
    DSQ_DIV  = 1'b0,
    DSQ_SQRT = 1'b1
  } dsq_op_t;

  typedef struct packed {
    logic                 start;
    dsq_op_t              op;
    logic [DSQ_W-1:0]     a;
    logic [DSQ_DIV_W-1:0] b;
  } dsq_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DSQ_W-1:0] result;
  } dsq_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/spo2r_if.sv
// Sample and result channel interfaces of the SpO2 estimator.
`timescale 1ns / 1ps
`default_nettype none
interface spo2r_in_if;
  logic                           valid;
  logic                           ready;
  logic [spo2r_pkg::SAMPLE_W-1:0] ir_sample;
  logic [spo2r_pkg::SAMPLE_W-1:0] red_sample;
  modport source (output valid, ir_sample, red_sample, input ready);
  modport sink (input valid, ir_sample, red_sample, output ready);
endinterface

interface spo2r_out_if;
  logic                         valid;
  logic                         ready;
  logic                         finger_present;
  logic                         reading_valid;
  logic [spo2r_pkg::SPO2_W-1:0] spo2_latest;
  logic [spo2r_pkg::SPO2_W-1:0] spo2_filtered;
  modport source (output valid, finger_present, reading_valid, spo2_latest, spo2_filtered,
                  input ready);
  modport sink (input valid, finger_present, reading_valid, spo2_latest, spo2_filtered,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spo2r_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module spo2r_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/spo2r_dsq.sv
// Iterative restoring divider and bit-pair integer square root, one step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module spo2r_dsq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire spo2r_pkg::dsq_req_t req,
  output spo2r_pkg::dsq_rsp_t      rsp
);

  logic                              busy_r;
  logic                              done_r;
  spo2r_pkg::dsq_op_t                op_r;
  logic [spo2r_pkg::DSQ_CNT_W-1:0]   cnt_r;
  logic [spo2r_pkg::DSQ_W-1:0]       x_r;
  logic [spo2r_pkg::DSQ_W-1:0]       q_r;
  logic [spo2r_pkg::DSQ_W-1:0]       bit_r;
  logic [spo2r_pkg::DSQ_DIV_W:0]     rem_r;
  logic [spo2r_pkg::DSQ_DIV_W-1:0]   b_r;

  logic [spo2r_pkg::DSQ_DIV_W:0]     rem_sh;
  logic                              rem_ge;
  logic [spo2r_pkg::DSQ_W-1:0]       sq_t;
  logic                              sq_ge;
  logic                              last;

  always_comb begin
    rem_sh = {rem_r[spo2r_pkg::DSQ_DIV_W-1:0], x_r[spo2r_pkg::DSQ_W-1]};
    rem_ge = rem_sh >= {1'b0, b_r};
    sq_t   = q_r + bit_r;
    sq_ge  = x_r >= sq_t;
    if (op_r == spo2r_pkg::DSQ_DIV) begin
      last = cnt_r == spo2r_pkg::DSQ_CNT_W'(spo2r_pkg::DIV_STEPS - 1);
    end else begin
      last = cnt_r == spo2r_pkg::DSQ_CNT_W'(spo2r_pkg::SQRT_STEPS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        x_r    <= req.a;
        b_r    <= req.b;
        rem_r  <= '0;
        q_r    <= '0;
        bit_r  <= {2'b01, {(spo2r_pkg::DSQ_W - 2){1'b0}}};
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (op_r == spo2r_pkg::DSQ_DIV) begin
          // shift in one dividend bit, subtract when it fits
          x_r <= {x_r[spo2r_pkg::DSQ_W-2:0], 1'b0};
          if (rem_ge) begin
            rem_r <= rem_sh - {1'b0, b_r};
            q_r   <= {q_r[spo2r_pkg::DSQ_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[spo2r_pkg::DSQ_W-2:0], 1'b0};
          end
        end else begin
          if (sq_ge) begin
            x_r <= x_r - sq_t;
            q_r <= {1'b0, q_r[spo2r_pkg::DSQ_W-1:1]} + bit_r;
          end else begin
            q_r <= {1'b0, q_r[spo2r_pkg::DSQ_W-1:1]};
          end
          bit_r <= {2'b00, bit_r[spo2r_pkg::DSQ_W-1:2]};
        end
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = q_r;

endmodule
`default_nettype wire

FILE: rtl/core/spo2_ratio_of_ratios.sv
// Top level of the ratio-of-ratios SpO2 estimator.
// Usage:
//   in_ch carries one IR / red sample pair per transaction; out_ch returns exactly one
//   result transaction per input (finger flag, reading flag, latest and smoothed SpO2).
//   Configuration registers are written on cfg_we with cfg_index / cfg_wdata while idle;
//   writing window_length empties the window (means are kept).
// Timing:
//   in_ch.ready is high only while the sequencer is idle. A sample with no finger goes
//   straight to the result. Otherwise the mean and window update run first, then per
//   channel a 64-step division by the window length and a 32-step square root, all on
//   one shared divide/square-root unit. A valid reading adds up to 14 normalize shifts,
//   a 64-step ratio division and 7 multiply steps on the shared multiplier for the
//   ratio terms, the curve and smoothing.
// Reset:
//   rst_n (synchronous, active low) restores register defaults and clears means, window
//   counters, sums and SpO2 history. No memory clearing pass is needed.
// Stall:
//   a result waits in the output register while out_ch.ready is low; the next sample is
//   taken meanwhile, and its result waits in the sequencer until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module spo2_ratio_of_ratios (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [spo2r_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spo2r_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  spo2r_in_if.sink                                in_ch,
  spo2r_out_if.source                             out_ch
);

  localparam int NST = 36;

  typedef enum logic [NST-1:0] {
    ST_IDLE = NST'(1) << 0,  ST_M0  = NST'(1) << 1,  ST_M1  = NST'(1) << 2,
    ST_M2   = NST'(1) << 3,  ST_M3  = NST'(1) << 4,  ST_M4  = NST'(1) << 5,
    ST_M5   = NST'(1) << 6,  ST_Q0  = NST'(1) << 7,  ST_Q1  = NST'(1) << 8,
    ST_Q2   = NST'(1) << 9,  ST_Q3  = NST'(1) << 10, ST_Q4  = NST'(1) << 11,
    ST_DV1  = NST'(1) << 12, ST_DW1 = NST'(1) << 13, ST_SQ1 = NST'(1) << 14,
    ST_SW1  = NST'(1) << 15, ST_DV2 = NST'(1) << 16, ST_DW2 = NST'(1) << 17,
    ST_SQ2  = NST'(1) << 18, ST_SW2 = NST'(1) << 19, ST_CHK = NST'(1) << 20,
    ST_N0   = NST'(1) << 21, ST_N1  = NST'(1) << 22, ST_N2  = NST'(1) << 23,
    ST_N3   = NST'(1) << 24, ST_SH  = NST'(1) << 25, ST_DVR = NST'(1) << 26,
    ST_DWR  = NST'(1) << 27, ST_C0  = NST'(1) << 28, ST_C1  = NST'(1) << 29,
    ST_C2   = NST'(1) << 30, ST_C3  = NST'(1) << 31, ST_F0  = NST'(1) << 32,
    ST_F1   = NST'(1) << 33, ST_F2  = NST'(1) << 34, ST_OUT = NST'(1) << 35
  } state_t;

  localparam int SW = spo2r_pkg::SLOT_W;
  localparam int FW = spo2r_pkg::FILL_W;

  // configuration
  logic [17:0] finger_threshold_r;
  logic [15:0] mean_gain_r;
  logic [15:0] smooth_gain_r;
  logic [25:0] min_ac_rms_r;
  logic [14:0] spo2_floor_r;
  logic [14:0] spo2_ceiling_r;
  logic [7:0]  window_length_r;

  // measurement state
  state_t                          state_r;
  logic [spo2r_pkg::MEAN_W-1:0]    ir_mean_r, red_mean_r;
  logic [spo2r_pkg::SUM_W-1:0]     ir_sum_r, red_sum_r;
  logic [SW-1:0]                   write_slot_r, slot_r;
  logic [FW-1:0]                   fill_level_r;
  logic [spo2r_pkg::SPO2_W-1:0]    spo2_last_r, spo2_smooth_r;

  // per-item working registers
  logic [spo2r_pkg::SAMPLE_W-1:0]  ir_r, red_r;
  logic signed [spo2r_pkg::RES_W-1:0] ir_res_r, red_res_r;
  logic [2*spo2r_pkg::RES_W-1:0]   old_r;
  logic                            was_full_r;
  logic [spo2r_pkg::RMS_W-1:0]     ir_rms_r, red_rms_r;
  logic [60:0]                     num_r, den_r;
  logic [16:0]                     r_r;
  logic [spo2r_pkg::SPO2_W-1:0]    s_r, base_r;
  logic [63:0]                     acc_r;
  logic                            finger_r, valid_r;

  // shared multiplier
  logic [33:0] mul_a;
  logic [26:0] mul_b;
  logic [60:0] p_r;

  // output register
  logic                            out_valid_r;
  logic                            out_finger_r, out_reading_r;
  logic [spo2r_pkg::SPO2_W-1:0]    out_latest_r, out_filtered_r;

  logic [FW-1:0]                   w_eff;
  logic [16:0]                     mean_comp, smooth_comp;
  logic [63:0]                     mean_sum, curve_sum, smooth_sum;
  logic [15:0]                     s16;
  logic [spo2r_pkg::SPO2_W-1:0]    s_clamped;
  logic [2*spo2r_pkg::RES_W-1:0]   ram_rdata;
  logic                            ram_we;
  logic                            accept;
  logic                            out_load;
  logic [FW-1:0]                   slot_inc;

  spo2r_pkg::dsq_req_t dsq_req;
  spo2r_pkg::dsq_rsp_t dsq_rsp;

  function automatic logic [spo2r_pkg::RES_W-1:0] mag(input logic [spo2r_pkg::RES_W-1:0] v);
    mag = v[spo2r_pkg::RES_W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    if (window_length_r == 8'd0) begin
      w_eff = FW'(1);
    end else if (32'(window_length_r) > spo2r_pkg::MAX_WINDOW) begin
      w_eff = FW'(spo2r_pkg::MAX_WINDOW);
    end else begin
      w_eff = FW'(window_length_r);
    end
  end

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = state_r == ST_IDLE;
  assign out_load    = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  assign ram_we      = state_r == ST_Q2;
  assign slot_inc    = FW'(slot_r) + 1'b1;

  assign mean_comp   = 17'h1_0000 - {1'b0, mean_gain_r};
  assign smooth_comp = 17'h1_0000 - {1'b0, smooth_gain_r};
  assign mean_sum    = acc_r + {p_r[47:0], 16'h0000};
  assign curve_sum   = acc_r - 64'(p_r) + 64'h0000_0080_0000_0000;
  assign smooth_sum  = acc_r + 64'(p_r) + 64'd32768;
  assign s16         = curve_sum[55:40];

  always_comb begin
    if (s16 < {1'b0, spo2_floor_r}) begin
      s_clamped = spo2_floor_r;
    end else if (s16 > {1'b0, spo2_ceiling_r}) begin
      s_clamped = spo2_ceiling_r;
    end else begin
      s_clamped = s16[14:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_M0: begin mul_a = ir_mean_r;          mul_b = 27'(mean_comp);        end
      ST_M1: begin mul_a = 34'(ir_r);          mul_b = 27'(mean_gain_r);      end
      ST_M2: begin mul_a = red_mean_r;         mul_b = 27'(mean_comp);        end
      ST_M3: begin mul_a = 34'(red_r);         mul_b = 27'(mean_gain_r);      end
      ST_Q0: begin mul_a = 34'(mag(ir_res_r));  mul_b = mag(ir_res_r);        end
      ST_Q1: begin mul_a = 34'(mag(red_res_r)); mul_b = mag(red_res_r);       end
      ST_Q2: begin
        mul_a = 34'(mag(old_r[2*spo2r_pkg::RES_W-1:spo2r_pkg::RES_W]));
        mul_b = mag(old_r[2*spo2r_pkg::RES_W-1:spo2r_pkg::RES_W]);
      end
      ST_Q3: begin
        mul_a = 34'(mag(old_r[spo2r_pkg::RES_W-1:0]));
        mul_b = mag(old_r[spo2r_pkg::RES_W-1:0]);
      end
      ST_N0: begin mul_a = ir_mean_r;          mul_b = red_rms_r;             end
      ST_N1: begin mul_a = red_mean_r;         mul_b = ir_rms_r;              end
      ST_C0: begin mul_a = 34'(r_r);           mul_b = 27'(spo2r_pkg::COEF_B); end
      ST_C1: begin mul_a = 34'(r_r);           mul_b = 27'(r_r);              end
      ST_C2: begin mul_a = p_r[33:0];          mul_b = 27'(spo2r_pkg::COEF_A); end
      ST_F0: begin mul_a = 34'(base_r);        mul_b = 27'(smooth_comp);      end
      ST_F1: begin mul_a = 34'(s_r);           mul_b = 27'(smooth_gain_r);    end
      default: begin mul_a = '0;               mul_b = '0;                    end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= 61'(mul_a) * 61'(mul_b);
  end

  always_comb begin
    dsq_req.start = 1'b0;
    dsq_req.op    = spo2r_pkg::DSQ_DIV;
    dsq_req.a     = '0;
    dsq_req.b     = 48'(w_eff);
    case (state_r)
      ST_DV1: begin
        dsq_req.start = 1'b1;
        dsq_req.a     = 64'(ir_sum_r);
      end
      ST_SQ1, ST_SQ2: begin
        dsq_req.start = 1'b1;
        dsq_req.op    = spo2r_pkg::DSQ_SQRT;
        dsq_req.a     = dsq_rsp.result;
      end
      ST_DV2: begin
        dsq_req.start = 1'b1;
        dsq_req.a     = 64'(red_sum_r);
      end
      ST_DVR: begin
        dsq_req.start = 1'b1;
        dsq_req.a     = {1'b0, num_r[46:0], 16'h0000};
        dsq_req.b     = den_r[47:0];
      end
      default: begin
        dsq_req.start = 1'b0;
      end
    endcase
  end

  spo2r_dsq u_dsq (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dsq_req),
    .rsp   (dsq_rsp)
  );

  spo2r_ram #(
    .WIDTH (2 * spo2r_pkg::RES_W),
    .DEPTH (spo2r_pkg::MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({ir_res_r, red_res_r}),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finger_threshold_r <= 18'd50000;
      mean_gain_r        <= 16'd3277;
      smooth_gain_r      <= 16'd13107;
      min_ac_rms_r       <= 26'd256;
      spo2_floor_r       <= 15'd17920;
      spo2_ceiling_r     <= 15'd25600;
      window_length_r    <= 8'd100;
      state_r            <= ST_IDLE;
      ir_mean_r          <= '0;
      red_mean_r         <= '0;
      ir_sum_r           <= '0;
      red_sum_r          <= '0;
      write_slot_r       <= '0;
      fill_level_r       <= '0;
      spo2_last_r        <= '0;
      spo2_smooth_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            ir_r   <= in_ch.ir_sample;
            red_r  <= in_ch.red_sample;
            slot_r <= (FW'(write_slot_r) < w_eff) ? write_slot_r : '0;
            if (in_ch.ir_sample < finger_threshold_r) begin
              // no finger: drop all measurement state
              ir_mean_r     <= '0;
              red_mean_r    <= '0;
              ir_sum_r      <= '0;
              red_sum_r     <= '0;
              write_slot_r  <= '0;
              fill_level_r  <= '0;
              spo2_last_r   <= '0;
              spo2_smooth_r <= '0;
              finger_r      <= 1'b0;
              valid_r       <= 1'b0;
              state_r       <= ST_OUT;
            end else begin
              finger_r <= 1'b1;
              valid_r  <= 1'b0;
              state_r  <= ST_M0;
            end
          end
        end
        ST_M0: state_r <= ST_M1;
        ST_M1: begin
          acc_r   <= 64'(p_r);
          state_r <= ST_M2;
        end
        ST_M2: begin
          ir_mean_r <= mean_sum[49:16];
          state_r   <= ST_M3;
        end
        ST_M3: begin
          acc_r   <= 64'(p_r);
          state_r <= ST_M4;
        end
        ST_M4: begin
          red_mean_r <= mean_sum[49:16];
          state_r    <= ST_M5;
        end
        ST_M5: begin
          old_r      <= ram_rdata;
          was_full_r <= fill_level_r >= w_eff;
          ir_res_r   <= {1'b0, ir_r, 8'h00} - {1'b0, ir_mean_r[33:8]};
          red_res_r  <= {1'b0, red_r, 8'h00} - {1'b0, red_mean_r[33:8]};
          state_r    <= ST_Q0;
        end
        ST_Q0: state_r <= ST_Q1;
        ST_Q1: begin
          ir_sum_r <= ir_sum_r + spo2r_pkg::SUM_W'(p_r);
          state_r  <= ST_Q2;
        end
        ST_Q2: begin
          red_sum_r <= red_sum_r + spo2r_pkg::SUM_W'(p_r);
          state_r   <= ST_Q3;
        end
        ST_Q3: begin
          if (was_full_r) begin
            ir_sum_r <= ir_sum_r - spo2r_pkg::SUM_W'(p_r);
          end
          state_r <= ST_Q4;
        end
        ST_Q4: begin
          if (was_full_r) begin
            red_sum_r <= red_sum_r - spo2r_pkg::SUM_W'(p_r);
          end
          write_slot_r <= (slot_inc >= w_eff) ? '0 : slot_r + 1'b1;
          if (fill_level_r < w_eff) begin
            fill_level_r <= fill_level_r + 1'b1;
          end
          state_r <= ST_DV1;
        end
        ST_DV1: state_r <= ST_DW1;
        ST_DW1: if (dsq_rsp.done) state_r <= ST_SQ1;
        ST_SQ1: state_r <= ST_SW1;
        ST_SW1: begin
          if (dsq_rsp.done) begin
            ir_rms_r <= dsq_rsp.result[spo2r_pkg::RMS_W-1:0];
            state_r  <= ST_DV2;
          end
        end
        ST_DV2: state_r <= ST_DW2;
        ST_DW2: if (dsq_rsp.done) state_r <= ST_SQ2;
        ST_SQ2: state_r <= ST_SW2;
        ST_SW2: begin
          if (dsq_rsp.done) begin
            red_rms_r <= dsq_rsp.result[spo2r_pkg::RMS_W-1:0];
            state_r   <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (fill_level_r >= w_eff && ir_mean_r > spo2r_pkg::MEAN_ONE &&
              red_mean_r > spo2r_pkg::MEAN_ONE &&
              ir_rms_r > 27'(min_ac_rms_r) && red_rms_r > 27'(min_ac_rms_r)) begin
            state_r <= ST_N0;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_N0: state_r <= ST_N1;
        ST_N1: begin
          num_r   <= p_r;
          state_r <= ST_N2;
        end
        ST_N2: begin
          den_r   <= p_r;
          state_r <= ST_N3;
        end
        ST_N3: begin
          if (num_r >= den_r) begin
            r_r     <= spo2r_pkg::R_ONE;
            state_r <= ST_C0;
          end else begin
            state_r <= ST_SH;
          end
        end
        ST_SH: begin
          // bring the divisor below 2^47, one bit a cycle
          if (|den_r[60:47]) begin
            den_r <= {1'b0, den_r[60:1]};
            num_r <= {1'b0, num_r[60:1]};
          end else begin
            state_r <= ST_DVR;
          end
        end
        ST_DVR: state_r <= ST_DWR;
        ST_DWR: begin
          if (dsq_rsp.done) begin
            if (dsq_rsp.result[16:0] < spo2r_pkg::R_LOW) begin
              r_r <= spo2r_pkg::R_LOW;
            end else begin
              r_r <= dsq_rsp.result[16:0];
            end
            state_r <= ST_C0;
          end
        end
        ST_C0: state_r <= ST_C1;
        ST_C1: begin
          acc_r   <= {9'h000, spo2r_pkg::COEF_C, 32'h0000_0000} + {p_r[47:0], 16'h0000};
          state_r <= ST_C2;
        end
        ST_C2: state_r <= ST_C3;
        ST_C3: begin
          s_r         <= s_clamped;
          spo2_last_r <= s_clamped;
          base_r      <= (spo2_smooth_r == '0) ? s_clamped : spo2_smooth_r;
          state_r     <= ST_F0;
        end
        ST_F0: state_r <= ST_F1;
        ST_F1: begin
          acc_r   <= 64'(p_r);
          state_r <= ST_F2;
        end
        ST_F2: begin
          spo2_smooth_r <= smooth_sum[30:16];
          valid_r       <= 1'b1;
          state_r       <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_index)
          spo2r_pkg::CFG_FINGER_THRESHOLD: finger_threshold_r <= cfg_wdata[17:0];
          spo2r_pkg::CFG_MEAN_GAIN:        mean_gain_r        <= cfg_wdata[15:0];
          spo2r_pkg::CFG_SMOOTH_GAIN:      smooth_gain_r      <= cfg_wdata[15:0];
          spo2r_pkg::CFG_MIN_AC_RMS:       min_ac_rms_r       <= cfg_wdata[25:0];
          spo2r_pkg::CFG_SPO2_FLOOR:       spo2_floor_r       <= cfg_wdata[14:0];
          spo2r_pkg::CFG_SPO2_CEILING:     spo2_ceiling_r     <= cfg_wdata[14:0];
          spo2r_pkg::CFG_WINDOW_LENGTH: begin
            // new window length: refill from empty
            window_length_r <= cfg_wdata[7:0];
            write_slot_r    <= '0;
            fill_level_r    <= '0;
            ir_sum_r        <= '0;
            red_sum_r       <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_finger_r   <= finger_r;
      out_reading_r  <= valid_r;
      out_latest_r   <= spo2_last_r;
      out_filtered_r <= spo2_smooth_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.finger_present = out_finger_r;
  assign out_ch.reading_valid  = out_reading_r;
  assign out_ch.spo2_latest    = out_latest_r;
  assign out_ch.spo2_filtered  = out_filtered_r;

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_level_r <= w_eff)
    else $error("fill level exceeds effective window");

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(write_slot_r) < w_eff)
    else $error("write slot outside effective window");

  a_reading_needs_finger: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.reading_valid |-> out_ch.finger_present)
    else $error("reading flagged without finger");

  a_dsq_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dsq_req.start |-> !dsq_rsp.busy)
    else $error("shared unit started while busy");

  a_accept_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("result load did not reach output register");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the ratio-of-ratios SpO2 estimator, with a built-in predictor.
`timescale 1ns / 1ps
module tb;

  localparam int LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic                         finger_present;
    logic                         reading_valid;
    logic [spo2r_pkg::SPO2_W-1:0] spo2_latest;
    logic [spo2r_pkg::SPO2_W-1:0] spo2_filtered;
  } spo2_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [spo2r_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [spo2r_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  spo2r_in_if  in_ch ();
  spo2r_out_if out_ch ();

  spo2_ratio_of_ratios dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Register copies for the predictor
  longint unsigned thr_q, mgain_q, sgain_q, min_rms_q, floor_q, ceil_q, winlen_q;
  // Measurement state of the predictor
  longint unsigned ir_avg, red_avg, ir_sqsum, red_sqsum, spo2_hold, spo2_avg;
  longint          ir_hist [spo2r_pkg::MAX_WINDOW];
  longint          red_hist [spo2r_pkg::MAX_WINDOW];
  int unsigned     slot_ptr, filled;

  spo2_result_t expected_readings[$];
  int           errors = 0;
  int           cycles = 0;
  int           sent = 0;
  bit           src_idle_en = 1'b0;
  bit           sink_stall_en = 1'b0;
  int           hold_off_cycles = 0;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint unsigned square_mag(input longint v);
    longint unsigned a;
    a = (v < 0) ? longint'(-v) : v;
    return a * a;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_window_model();
    slot_ptr = 0;
    filled = 0;
    ir_sqsum = 0;
    red_sqsum = 0;
  endfunction

  function automatic void clear_all_model();
    ir_avg = 0;
    red_avg = 0;
    foreach (ir_hist[i]) begin
      ir_hist[i] = 0;
      red_hist[i] = 0;
    end
    clear_window_model();
    spo2_hold = 0;
    spo2_avg = 0;
  endfunction

  function automatic spo2_result_t predict_reading(
      input logic [spo2r_pkg::SAMPLE_W-1:0] ir_s,
      input logic [spo2r_pkg::SAMPLE_W-1:0] red_s);
    spo2_result_t    res;
    longint unsigned x_ir, x_red, w, ir_rms, red_rms, num, den, r, s, pos, neg;
    longint          ir_res, red_res;
    int unsigned     slot;
    x_ir = ir_s;
    x_red = red_s;
    w = (winlen_q < 1) ? 1 : ((winlen_q > spo2r_pkg::MAX_WINDOW) ? spo2r_pkg::MAX_WINDOW
                                                                 : winlen_q);
    res = '0;
    if (x_ir < thr_q) begin
      clear_all_model();
      return res;
    end
    ir_avg = ((65536 - mgain_q) * ir_avg + mgain_q * (x_ir << 16)) >> 16;
    red_avg = ((65536 - mgain_q) * red_avg + mgain_q * (x_red << 16)) >> 16;
    ir_res = longint'(x_ir << 8) - longint'(ir_avg >> 8);
    red_res = longint'(x_red << 8) - longint'(red_avg >> 8);
    slot = (slot_ptr < w) ? slot_ptr : 0;
    if (filled >= w) begin
      ir_sqsum -= square_mag(ir_hist[slot]);
      red_sqsum -= square_mag(red_hist[slot]);
    end
    ir_hist[slot] = ir_res;
    red_hist[slot] = red_res;
    ir_sqsum += square_mag(ir_res);
    red_sqsum += square_mag(red_res);
    slot_ptr = (slot + 1 >= w) ? 0 : slot + 1;
    if (filled < w) filled++;
    ir_rms = int_sqrt(ir_sqsum / w);
    red_rms = int_sqrt(red_sqsum / w);
    res.finger_present = 1'b1;
    if (filled >= w && ir_avg > 65536 && red_avg > 65536 &&
        ir_rms > min_rms_q && red_rms > min_rms_q) begin
      res.reading_valid = 1'b1;
      num = red_rms * ir_avg;
      den = ir_rms * red_avg;
      if (num >= den) begin
        r = 64'(spo2r_pkg::R_ONE);
      end else begin
        while (den >= (64'd1 << 47)) begin
          den >>= 1;
          num >>= 1;
        end
        r = (num << 16) / den;
        if (r < spo2r_pkg::R_LOW) r = 64'(spo2r_pkg::R_LOW);
      end
      pos = (longint'(spo2r_pkg::COEF_C) << 32) + ((longint'(spo2r_pkg::COEF_B) * r) << 16);
      neg = longint'(spo2r_pkg::COEF_A) * r * r;
      s = (pos - neg + (64'd1 << 39)) >> 40;
      // floor check comes first: with floor above ceiling, s below floor gets floor, else ceiling
      if (s < floor_q) s = floor_q;
      else if (s > ceil_q) s = ceil_q;
      spo2_hold = s;
      if (spo2_avg == 0) spo2_avg = s;
      spo2_avg = ((65536 - sgain_q) * spo2_avg + sgain_q * s + 32768) >> 16;
    end
    res.spo2_latest = spo2_hold[spo2r_pkg::SPO2_W-1:0];
    res.spo2_filtered = spo2_avg[spo2r_pkg::SPO2_W-1:0];
    return res;
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk) begin
    spo2_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        report("result transaction with no expectation pending");
      end else begin
        e = expected_readings.pop_front();
        if (out_ch.finger_present !== e.finger_present)
          report($sformatf("finger_present %0b exp %0b", out_ch.finger_present,
                           e.finger_present));
        if (out_ch.reading_valid !== e.reading_valid)
          report($sformatf("reading_valid %0b exp %0b", out_ch.reading_valid,
                           e.reading_valid));
        if (out_ch.spo2_latest !== e.spo2_latest)
          report($sformatf("spo2_latest %0d exp %0d", out_ch.spo2_latest, e.spo2_latest));
        if (out_ch.spo2_filtered !== e.spo2_filtered)
          report($sformatf("spo2_filtered %0d exp %0d", out_ch.spo2_filtered,
                           e.spo2_filtered));
      end
    end
  end

  // Result receiver: random stalls and requested long hold-offs
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (sink_stall_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Offer one sample pair; valid stays high for a following sample
  task automatic send_sample(input logic [spo2r_pkg::SAMPLE_W-1:0] ir_s,
                             input logic [spo2r_pkg::SAMPLE_W-1:0] red_s);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ir_sample <= ir_s;
    in_ch.red_sample <= red_s;
    do @(posedge clk); while (!in_ch.ready);
    expected_readings.push_back(predict_reading(ir_s, red_s));
    sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_registers(input longint unsigned thr, mg, sg, mr, fl, cl, wl);
    longint unsigned vals [7];
    vals = '{thr, mg, sg, mr, fl, cl, wl};
    wait_idle();
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= spo2r_pkg::CFG_IDX_W'(i);
      cfg_wdata <= spo2r_pkg::CFG_DATA_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    thr_q = thr & 64'h3FFFF;
    mgain_q = mg & 64'hFFFF;
    sgain_q = sg & 64'hFFFF;
    min_rms_q = mr & 64'h3FFFFFF;
    floor_q = fl & 64'h7FFF;
    ceil_q = cl & 64'h7FFF;
    winlen_q = wl & 64'hFF;
    clear_window_model();
  endtask

  task automatic random_registers();
    longint unsigned thr, mg, sg, mr, fl, cl, wl;
    case ($urandom_range(0, 9))
      0: thr = 0;
      1: thr = 262143;
      default: thr = $urandom_range(1000, 80000);
    endcase
    case ($urandom_range(0, 9))
      0: mg = 0;
      1: mg = 65535;
      default: mg = $urandom_range(500, 12000);
    endcase
    case ($urandom_range(0, 9))
      0: sg = 0;
      1: sg = 65535;
      default: sg = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 14))
      0: mr = 67108863;
      1: mr = $urandom_range(0, 67108863);
      default: mr = $urandom_range(0, 3000);
    endcase
    case ($urandom_range(0, 7))
      0: begin fl = 25600; cl = 0; end
      1: begin fl = 0; cl = $urandom_range(0, 25600); end
      2: begin fl = $urandom_range(0, 25600); cl = $urandom_range(0, 25600); end
      default: begin fl = $urandom_range(15000, 22000); cl = $urandom_range(23000, 25600); end
    endcase
    case ($urandom_range(0, 19))
      0: wl = 0;
      1: wl = 1;
      2: wl = 128;
      3: wl = $urandom_range(129, 255);
      default: wl = $urandom_range(2, 32);
    endcase
    write_registers(thr, mg, sg, mr, fl, cl, wl);
  endtask

  // Finger-on stretch: samples around a level with random AC content
  task automatic pulse_run(input int n);
    longint unsigned lo, b_ir, b_red, a_ir, a_red, v_ir, v_red;
    lo = (thr_q > 262143) ? 262143 : thr_q;
    a_ir = $urandom_range(0, 1) ? $urandom_range(50, 4000) : $urandom_range(0, 30000);
    a_red = $urandom_range(0, 1) ? $urandom_range(50, 4000) : $urandom_range(0, 30000);
    if (lo + 2 * a_ir > 262143) a_ir = (262143 - lo) / 2;
    b_ir = $urandom_range(lo + a_ir, 262143 - a_ir);
    b_red = $urandom_range(a_red, 262143 - a_red);
    for (int i = 0; i < n; i++) begin
      v_ir = b_ir - a_ir + $urandom_range(0, 2 * a_ir);
      v_red = b_red - a_red + $urandom_range(0, 2 * a_red);
      send_sample(spo2r_pkg::SAMPLE_W'(v_ir), spo2r_pkg::SAMPLE_W'(v_red));
    end
  endtask

  task automatic test_directed();
    send_sample(0, 0);
    send_sample(49999, 5);
    send_sample(50000, 262143);
    send_sample(262143, 0);
    // single-entry window gives readings right away
    write_registers(50000, 65535, 65535, 0, 17920, 25600, 1);
    send_sample(262143, 262143);
    send_sample(60000, 262143);
    send_sample(262143, 1000);
    send_sample(100000, 200000);
    send_sample(150000, 30000);
    // floor above ceiling, zero window, zero smoothing gain
    write_registers(0, 3277, 0, 0, 25600, 0, 0);
    send_sample(0, 0);
    send_sample(200000, 100000);
    send_sample(10, 262143);
    write_registers(262143, 0, 13107, 67108863, 0, 0, 200);
    send_sample(262142, 7);
    send_sample(262143, 262143);
    write_registers(1000, 20000, 20000, 10, 0, 25600, 2);
    send_sample(90000, 90000);
    send_sample(95000, 80000);
    send_sample(85000, 99000);
    send_sample(999, 99000);
    send_sample(91000, 85000);
    send_sample(93000, 88000);
  endtask

  task automatic test_random_pulses(input int target);
    while (sent < target) begin
      if ($urandom_range(0, 3) == 0) random_registers();
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 8))
          send_sample(spo2r_pkg::SAMPLE_W'($urandom), spo2r_pkg::SAMPLE_W'($urandom));
      end else begin
        pulse_run((winlen_q > 32 && winlen_q != 0) ? $urandom_range(130, 170)
                                                   : $urandom_range(20, 80));
      end
    end
  endtask

  task automatic test_backpressure();
    write_registers(20000, 4000, 13107, 100, 17920, 25600, 4);
    hold_off_cycles = 3000;
    pulse_run(12);
  endtask

  task automatic test_clean_stream();
    src_idle_en = 1'b0;
    sink_stall_en = 1'b0;
    write_registers(30000, 6000, 20000, 50, 17000, 25600, 8);
    pulse_run(60);
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.ir_sample <= '0;
    in_ch.red_sample <= '0;
    thr_q = 50000; mgain_q = 3277; sgain_q = 13107; min_rms_q = 256;
    floor_q = 17920; ceil_q = 25600; winlen_q = 100;
    clear_all_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_idle_en = 1'b1;
    sink_stall_en = 1'b1;
    test_directed();
    test_random_pulses(1500);
    test_backpressure();
    test_random_pulses(1590);
    test_clean_stream();
    wait_idle();
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
